// File: design/brc_pkg.sv
// Package for the barometer reading compensation block.
// Holds the calibration record, controller states, datapath command codes
// and fixed-point constants shared by the controller, datapath and CSR files.
package brc_pkg;

   localparam int RAW_W   = 24;
   localparam int CAL_W   = 16;
   localparam int DT_W    = 26;
   localparam int TEMP_W  = 19;
   localparam int PRESS_W = 41;
   localparam int MUL_W   = 26;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int OFF_W   = 42;
   localparam int SENS_W  = 40;
   localparam int ACC_W   = 64;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;
   localparam int NUM_REGS = 6;

   localparam int TEMP_BASE  = 2000;
   localparam int COLD_LIMIT = -1500;

   // Power-of-two scalings of the compensation formulas.
   localparam int TREF_SHIFT = 8;
   localparam int T_SHIFT    = 23;
   localparam int OFF_SCALE  = 16;
   localparam int OFF_SHIFT  = 7;
   localparam int SENS_SCALE = 15;
   localparam int SENS_SHIFT = 8;
   localparam int DT2_SHIFT  = 31;
   localparam int P_SHIFT    = 21;
   localparam int SPLIT_W    = 20;

   localparam logic [2:0] REG_SENS     = 3'd0;
   localparam logic [2:0] REG_OFF      = 3'd1;
   localparam logic [2:0] REG_TCS      = 3'd2;
   localparam logic [2:0] REG_TCO      = 3'd3;
   localparam logic [2:0] REG_TREF     = 3'd4;
   localparam logic [2:0] REG_TEMPSENS = 3'd5;

   typedef struct packed {
      logic [CAL_W-1:0] sens;
      logic [CAL_W-1:0] off;
      logic [CAL_W-1:0] tcs;
      logic [CAL_W-1:0] tco;
      logic [CAL_W-1:0] tref;
      logic [CAL_W-1:0] tempsens;
   } cal_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_T_DIFF,
      ST_T_MUL,
      ST_T_FIN,
      ST_OFF_MUL,
      ST_OFF_ACC,
      ST_SENS_MUL,
      ST_SENS_ACC,
      ST_DT2_MUL,
      ST_DT2_ACC,
      ST_A_MUL,
      ST_A_ACC,
      ST_B_MUL,
      ST_B_ACC,
      ST_PL_MUL,
      ST_PL_ACC,
      ST_PH_MUL,
      ST_PH_ACC,
      ST_P_FIN,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_T,
      MUL_OFF,
      MUL_SENS,
      MUL_DT2,
      MUL_A,
      MUL_B,
      MUL_PL,
      MUL_PH
   } mul_sel_type;

   typedef enum logic [3:0] {
      ACC_NONE,
      ACC_DIFF,
      ACC_TFIN,
      ACC_OFF,
      ACC_SENS,
      ACC_DT2,
      ACC_A,
      ACC_B,
      ACC_PL,
      ACC_PH,
      ACC_PFIN
   } acc_op_type;

   typedef struct packed {
      logic        load_req;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic t_below_base;
      logic t_below_cold;
   } status_type;

endpackage

// File: design/brc_csr.sv
// Calibration register file with an APB-style write/read port.
// Depends on brc_pkg for the calibration record and register indexes.
module brc_csr
   import brc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cal_type           cal
);

   cal_type    cal_ff;
   cal_type    cal_in;
   logic [2:0] index;
   logic       write_en;

   assign index    = paddr[ADDR_W-1:2];
   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;
   assign cal      = cal_ff;

   always_comb begin
      cal_in = cal_ff;
      if (write_en) begin
         case (index)
            REG_SENS:     cal_in.sens     = pwdata[CAL_W-1:0];
            REG_OFF:      cal_in.off      = pwdata[CAL_W-1:0];
            REG_TCS:      cal_in.tcs      = pwdata[CAL_W-1:0];
            REG_TCO:      cal_in.tco      = pwdata[CAL_W-1:0];
            REG_TREF:     cal_in.tref     = pwdata[CAL_W-1:0];
            REG_TEMPSENS: cal_in.tempsens = pwdata[CAL_W-1:0];
            default:      cal_in = cal_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_SENS:     prdata = {{(DATA_W-CAL_W){1'b0}}, cal_ff.sens};
         REG_OFF:      prdata = {{(DATA_W-CAL_W){1'b0}}, cal_ff.off};
         REG_TCS:      prdata = {{(DATA_W-CAL_W){1'b0}}, cal_ff.tcs};
         REG_TCO:      prdata = {{(DATA_W-CAL_W){1'b0}}, cal_ff.tco};
         REG_TREF:     prdata = {{(DATA_W-CAL_W){1'b0}}, cal_ff.tref};
         REG_TEMPSENS: prdata = {{(DATA_W-CAL_W){1'b0}}, cal_ff.tempsens};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

endmodule

// File: design/brc_ctrl.sv
// Sequencing controller: steps the shared multiplier through the formulas.
// Depends on brc_pkg for the state, command and status types.
module brc_ctrl
   import brc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_op,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_tvalid_ff;
   logic      rsp_tvalid_in;
   logic      out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = req_op ? ST_OFF_MUL : ST_T_DIFF;
            end
         end
         ST_T_DIFF:   state_in = ST_T_MUL;
         ST_T_MUL:    state_in = ST_T_FIN;
         ST_T_FIN:    state_in = ST_DONE;
         ST_OFF_MUL:  state_in = ST_OFF_ACC;
         ST_OFF_ACC:  state_in = ST_SENS_MUL;
         ST_SENS_MUL: state_in = ST_SENS_ACC;
         ST_SENS_ACC: state_in = status.t_below_base ? ST_DT2_MUL : ST_PL_MUL;
         ST_DT2_MUL:  state_in = ST_DT2_ACC;
         ST_DT2_ACC:  state_in = ST_A_MUL;
         ST_A_MUL:    state_in = ST_A_ACC;
         ST_A_ACC:    state_in = status.t_below_cold ? ST_B_MUL : ST_PL_MUL;
         ST_B_MUL:    state_in = ST_B_ACC;
         ST_B_ACC:    state_in = ST_PL_MUL;
         ST_PL_MUL:   state_in = ST_PL_ACC;
         ST_PL_ACC:   state_in = ST_PH_MUL;
         ST_PH_MUL:   state_in = ST_PH_ACC;
         ST_PH_ACC:   state_in = ST_P_FIN;
         ST_P_FIN:    state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.load_req = 1'b0;
      cmd.mul_sel  = MUL_NONE;
      cmd.acc_op   = ACC_NONE;
      cmd.load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE:     cmd.load_req = req_tvalid;
         ST_T_DIFF:   cmd.acc_op   = ACC_DIFF;
         ST_T_MUL:    cmd.mul_sel  = MUL_T;
         ST_T_FIN:    cmd.acc_op   = ACC_TFIN;
         ST_OFF_MUL:  cmd.mul_sel  = MUL_OFF;
         ST_OFF_ACC:  cmd.acc_op   = ACC_OFF;
         ST_SENS_MUL: cmd.mul_sel  = MUL_SENS;
         ST_SENS_ACC: cmd.acc_op   = ACC_SENS;
         ST_DT2_MUL:  cmd.mul_sel  = MUL_DT2;
         ST_DT2_ACC:  cmd.acc_op   = ACC_DT2;
         ST_A_MUL:    cmd.mul_sel  = MUL_A;
         ST_A_ACC:    cmd.acc_op   = ACC_A;
         ST_B_MUL:    cmd.mul_sel  = MUL_B;
         ST_B_ACC:    cmd.acc_op   = ACC_B;
         ST_PL_MUL:   cmd.mul_sel  = MUL_PL;
         ST_PL_ACC:   cmd.acc_op   = ACC_PL;
         ST_PH_MUL:   cmd.mul_sel  = MUL_PH;
         ST_PH_ACC:   cmd.acc_op   = ACC_PH;
         ST_P_FIN:    cmd.acc_op   = ACC_PFIN;
         ST_DONE:     cmd.load_rsp = out_free;
         default:     cmd.load_req = 1'b0;
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd.load_rsp) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_T_DIFF || state_ff == ST_OFF_MUL)
      else $error("accepted beat did not start a compensation sequence");

   a_load_shows_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_tvalid_ff)
      else $error("loaded result was not presented on the result channel");

   a_cold_after_square: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_B_MUL |-> $past(state_ff) == ST_A_ACC)
      else $error("cold correction entered without the low temperature term");

endmodule

// File: design/brc_dp.sv
// Compensation datapath: one shared 26x26 multiplier with a registered
// product, plus the offset, sensitivity and product accumulators. Uses brc_pkg.
module brc_dp
   import brc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  cal_type                  cal,
   input  logic [RAW_W-1:0]         req_raw,
   output status_type               status,
   output logic signed [TEMP_W-1:0] rsp_temp,
   output logic signed [PRESS_W-1:0] rsp_press,
   output logic                     rsp_pvalid
);

   logic [RAW_W-1:0]          raw_ff;
   logic signed [DT_W-1:0]    dt_ff;
   logic signed [TEMP_W-1:0]  t_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [OFF_W-1:0]   off_ff;
   logic signed [SENS_W-1:0]  sens_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [TEMP_W-1:0]  tout_ff;
   logic signed [PRESS_W-1:0] press_ff;
   logic                      pvalid_ff;
   logic signed [TEMP_W-1:0]  rsp_temp_ff;
   logic signed [PRESS_W-1:0] rsp_press_ff;
   logic                      rsp_pvalid_ff;

   logic signed [MUL_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_b;
   logic signed [DT_W-1:0]    diff;
   logic signed [MUL_W-1:0]   t_ext;
   logic signed [MUL_W-1:0]   t_warm;
   logic signed [MUL_W-1:0]   t_cold;
   logic                      psign;
   logic signed [PROD_W-1:0]  t_quot;
   logic signed [PROD_W-1:0]  off_quot;
   logic signed [PROD_W-1:0]  sens_quot;
   logic [SENS_W-1:0]         square;
   logic [SENS_W+1:0]         five_a;
   logic [SENS_W+2:0]         seven_b;
   logic [SENS_W+3:0]         eleven_b;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   p_quot;

   assign diff = $signed({2'b00, raw_ff}) -
                 $signed({{(DT_W-CAL_W-TREF_SHIFT){1'b0}}, cal.tref, {TREF_SHIFT{1'b0}}});
   assign t_ext  = {{(MUL_W-TEMP_W){t_ff[TEMP_W-1]}}, t_ff};
   assign t_warm = t_ext - MUL_W'(TEMP_BASE);
   assign t_cold = t_ext - MUL_W'(COLD_LIMIT);

   assign status.t_below_base = t_ff < TEMP_W'(TEMP_BASE);
   assign status.t_below_cold = t_ff < TEMP_W'(COLD_LIMIT);

   always_comb begin
      case (cmd.mul_sel)
         MUL_T: begin
            mul_a = dt_ff;
            mul_b = $signed({{(MUL_W-CAL_W){1'b0}}, cal.tempsens});
         end
         MUL_OFF: begin
            mul_a = dt_ff;
            mul_b = $signed({{(MUL_W-CAL_W){1'b0}}, cal.tco});
         end
         MUL_SENS: begin
            mul_a = dt_ff;
            mul_b = $signed({{(MUL_W-CAL_W){1'b0}}, cal.tcs});
         end
         MUL_DT2: begin
            mul_a = dt_ff;
            mul_b = dt_ff;
         end
         MUL_A: begin
            mul_a = t_warm;
            mul_b = t_warm;
         end
         MUL_B: begin
            mul_a = t_cold;
            mul_b = t_cold;
         end
         MUL_PL: begin
            mul_a = $signed({2'b00, raw_ff});
            mul_b = $signed({{(MUL_W-SPLIT_W){1'b0}}, sens_ff[SPLIT_W-1:0]});
         end
         MUL_PH: begin
            mul_a = $signed({2'b00, raw_ff});
            mul_b = {{(MUL_W-SENS_W+SPLIT_W){sens_ff[SENS_W-1]}},
                     sens_ff[SENS_W-1:SPLIT_W]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Signed quotients by powers of two round toward zero: negative
   // products get the divisor minus one added before the arithmetic shift.
   assign psign     = prod_ff[PROD_W-1];
   assign t_quot    = (prod_ff + $signed({{(PROD_W-T_SHIFT){1'b0}}, {T_SHIFT{psign}}}))
                      >>> T_SHIFT;
   assign off_quot  = (prod_ff + $signed({{(PROD_W-OFF_SHIFT){1'b0}}, {OFF_SHIFT{psign}}}))
                      >>> OFF_SHIFT;
   assign sens_quot = (prod_ff + $signed({{(PROD_W-SENS_SHIFT){1'b0}}, {SENS_SHIFT{psign}}}))
                      >>> SENS_SHIFT;

   // Squares are non-negative, so their halvings are plain right shifts.
   assign square   = prod_ff[SENS_W-1:0];
   assign five_a   = {square, 2'b00} + {2'b00, square};
   assign seven_b  = {square, 3'b000} - {3'b000, square};
   assign eleven_b = {square, 3'b000} + {2'b00, square, 1'b0} + {4'b0000, square};

   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign p_quot   = (acc_ff + $signed({{(ACC_W-P_SHIFT){1'b0}}, {P_SHIFT{acc_ff[ACC_W-1]}}}))
                     >>> P_SHIFT;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.load_req) begin
         raw_ff <= req_raw;
      end
      case (cmd.acc_op)
         ACC_TFIN: begin
            tout_ff   <= TEMP_W'(TEMP_BASE) + t_quot[TEMP_W-1:0];
            press_ff  <= '0;
            pvalid_ff <= 1'b0;
         end
         ACC_OFF: begin
            off_ff    <= $signed({{(OFF_W-CAL_W-OFF_SCALE){1'b0}}, cal.off, {OFF_SCALE{1'b0}}})
                         + off_quot[OFF_W-1:0];
            tout_ff   <= t_ff;
            pvalid_ff <= 1'b1;
         end
         ACC_SENS: begin
            sens_ff <= $signed({{(SENS_W-CAL_W-SENS_SCALE){1'b0}}, cal.sens,
                                {SENS_SCALE{1'b0}}}) + sens_quot[SENS_W-1:0];
         end
         ACC_DT2: begin
            tout_ff <= t_ff - $signed(prod_ff[DT2_SHIFT+TEMP_W-1:DT2_SHIFT]);
         end
         ACC_A: begin
            off_ff  <= off_ff - $signed({1'b0, five_a[SENS_W+1:1]});
            sens_ff <= sens_ff - $signed(five_a[SENS_W+1:2]);
         end
         ACC_B: begin
            off_ff  <= off_ff - $signed(seven_b[OFF_W-1:0]);
            sens_ff <= sens_ff - $signed(eleven_b[SENS_W:1]);
         end
         ACC_PL: begin
            acc_ff <= prod_ext;
         end
         ACC_PH: begin
            acc_ff <= acc_ff + (prod_ext <<< SPLIT_W);
         end
         ACC_PFIN: begin
            press_ff <= p_quot[PRESS_W-1:0] - off_ff[PRESS_W-1:0];
         end
         default: begin
            acc_ff <= acc_ff;
         end
      endcase
      if (cmd.load_rsp) begin
         rsp_temp_ff   <= tout_ff;
         rsp_press_ff  <= press_ff;
         rsp_pvalid_ff <= pvalid_ff;
      end
   end

   // Stored temperature state: written only by a temperature beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= '0;
         t_ff  <= '0;
      end else begin
         if (cmd.acc_op == ACC_DIFF) begin
            dt_ff <= diff;
         end
         if (cmd.acc_op == ACC_TFIN) begin
            t_ff <= TEMP_W'(TEMP_BASE) + t_quot[TEMP_W-1:0];
         end
      end
   end

   assign rsp_temp   = rsp_temp_ff;
   assign rsp_press  = rsp_press_ff;
   assign rsp_pvalid = rsp_pvalid_ff;

   a_raw_captured: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> raw_ff == $past(req_raw))
      else $error("raw sample was not captured on acceptance");

   a_temp_state_holds: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_op != ACC_TFIN |=> $stable(t_ff))
      else $error("stored temperature changed outside a temperature beat");

   a_temp_beat_no_press: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_op == ACC_TFIN |=> press_ff == '0 && !pvalid_ff && tout_ff == t_ff)
      else $error("temperature beat left a pressure result behind");

endmodule

// File: design/barometer_reading_compensation_top.sv
// Barometer reading compensation built around the single shared 26x26
// multiplier, whose product is registered and consumed in the following cycle,
// so every product takes a multiply state and an accumulate state. A pressure
// beat adds the second-order steps below 20.00 degrees and the cold-correction
// steps below -15.00 degrees. The result sits in an output register, so the
// next beat is taken while a finished result waits. The temperature beat
// stores dT and the first-order temperature for later pressure beats; the
// user must write calibration words through the CSR port only while idle,
// and the block itself does not enforce it.
module barometer_reading_compensation_top
   import brc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,  // [23:0] raw_sample
   input  logic              req_tuser,  // [0] op
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [63:0]       rsp_tdata,  // [18:0] temperature_centi, [59:19] pressure_q15
   output logic              rsp_tuser,  // [0] pressure_valid
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cal_type                   cal;
   cmd_type                   cmd;
   status_type                status;
   logic signed [TEMP_W-1:0]  rsp_temp;
   logic signed [PRESS_W-1:0] rsp_press;
   logic                      rsp_pvalid;

   brc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cal     (cal)
   );

   brc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   brc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cal        (cal),
      .req_raw    (req_tdata),
      .status     (status),
      .rsp_temp   (rsp_temp),
      .rsp_press  (rsp_press),
      .rsp_pvalid (rsp_pvalid)
   );

   assign rsp_tdata = {{(64-TEMP_W-PRESS_W){1'b0}}, rsp_press, rsp_temp};
   assign rsp_tuser = rsp_pvalid;

endmodule
